@@ src/ltbx_pkg.sv @@
// ----------------------------------------------------------------------------
// ltbx_pkg
// Shared types and constants of the letterbox resize address generator:
// register codes, divider operand selection and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ltbx_pkg;

  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 24;

  localparam logic [REG_W-1:0] SRC_W_RST = 13'd640;
  localparam logic [REG_W-1:0] SRC_H_RST = 13'd480;
  localparam logic [REG_W-1:0] DST_W_RST = 13'd300;
  localparam logic [REG_W-1:0] DST_H_RST = 13'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_DST_W = 3'd2,
    REG_DST_H = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DQ_SCALE_W,
    DQ_SCALE_H,
    DQ_FIT_H,
    DQ_FIT_W
  } div_sel_t;

  typedef struct packed {
    logic     derive_clr;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_store;
    logic     walk_mul;
    logic     walk_add;
    logic     out_load;
  } ltbx_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic div_busy;
    logic div_done;
    logic empty;
    logic slot_free;
  } ltbx_sts_t;

endpackage

@@ src/ltbx_div.sv @@
// ----------------------------------------------------------------------------
// ltbx_div
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ltbx_div #(
  parameter int W = 27
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         clr,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int CW = $clog2(W + 1);

  logic         busy_r;
  logic         done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] quo_r;
  logic [W-1:0] den_r;

  logic [W:0]   trial;
  logic [W+1:0] diff;
  logic         take;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    diff    = {1'b0, trial} - {2'b00, den_r};
    take    = ~diff[W+1];
    rem_nxt = take ? diff[W-1:0] : trial[W-1:0];
    quo_nxt = {quo_r[W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (clr) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ src/ltbx_dp.sv @@
// ----------------------------------------------------------------------------
// ltbx_dp
// Datapath: size registers, derivation of scale and margins through the
// shared divider, the raster walk counters, the two multiply stages of the
// address computation and the output register.
// ----------------------------------------------------------------------------
module ltbx_dp #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ltbx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ltbx_pkg::REG_W-1:0]       cfg_data,
  input  ltbx_pkg::ltbx_cmd_t              cmd,
  output ltbx_pkg::ltbx_sts_t              sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [ltbx_pkg::IDX_W-1:0]       out_source_index,
  output logic [ltbx_pkg::IDX_W-1:0]       out_dest_index,
  output logic                             out_frame_last,
  output logic                             out_empty_area
);

  import ltbx_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int SC_W  = DIM_W + FRAC_BITS;
  localparam int CMP_W = (DIM_W > REG_W) ? DIM_W : REG_W;
  localparam int PY_W  = CNT_W + SC_W;
  localparam int PD_W  = CNT_W + 1 + DIM_W;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [REG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve == '0) return DIM_W'(1);
    if (ve > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return DIM_W'(ve);
  endfunction

  logic [REG_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [DIM_W-1:0] sw, sh, tw, th;
  logic             cfg_hit;

  logic [SC_W-1:0]  sc_w_r;
  logic [SC_W-1:0]  scale_r;
  logic [CNT_W-1:0] row_margin_r, col_margin_r;
  logic [DIM_W-1:0] act_h_r, act_w_r;

  logic [SC_W-1:0]  div_num, div_den, div_quo;
  logic             div_busy, div_done;

  logic [SC_W-1:0]  sc_max;
  logic [DIM_W-1:0] m_out, m_diff, m_half, m_act;
  logic             fit_ge;

  logic [CNT_W-1:0] row_count_r, col_count_r;
  logic             row_end, col_end, last, empty;

  logic [PY_W-1:0]  py_r, px_r;
  logic [PD_W-1:0]  dprod_r;
  logic [IDX_W-1:0] sy_idx;
  logic [IDX_W-1:0] sprod_r, sx_r, dsum_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_src_r, out_dst_r;
  logic             out_last_r, out_empty_r;

  assign sw = sat_dim(src_w_r);
  assign sh = sat_dim(src_h_r);
  assign tw = sat_dim(dst_w_r);
  assign th = sat_dim(dst_h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_W_RST;
      src_h_r <= SRC_H_RST;
      dst_w_r <= DST_W_RST;
      dst_h_r <= DST_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_W: src_w_r <= cfg_data;
        REG_SRC_H: src_h_r <= cfg_data;
        REG_DST_W: dst_w_r <= cfg_data;
        REG_DST_H: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(cfg_index)) inside
      REG_SRC_W, REG_SRC_H, REG_DST_W, REG_DST_H: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd.div_sel)
      DQ_SCALE_W: begin
        div_num = SC_W'(sw) << FRAC_BITS;
        div_den = SC_W'(tw);
      end
      DQ_SCALE_H: begin
        div_num = SC_W'(sh) << FRAC_BITS;
        div_den = SC_W'(th);
      end
      DQ_FIT_H: begin
        div_num = SC_W'(sh) << FRAC_BITS;
        div_den = scale_r;
      end
      DQ_FIT_W: begin
        div_num = SC_W'(sw) << FRAC_BITS;
        div_den = scale_r;
      end
    endcase
  end

  ltbx_div #(
    .W(SC_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .clr  (cmd.derive_clr),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  always_comb begin
    sc_max = (sc_w_r > div_quo) ? sc_w_r : div_quo;
    if (sc_max == '0) begin
      sc_max = SC_W'(1);
    end
    m_out  = (cmd.div_sel == DQ_FIT_H) ? th : tw;
    fit_ge = div_quo >= SC_W'(m_out);
    m_diff = m_out - DIM_W'(div_quo);
    m_half = fit_ge ? '0 : (m_diff >> 1);
    m_act  = m_out - (m_half << 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        DQ_SCALE_W: sc_w_r <= div_quo;
        DQ_SCALE_H: scale_r <= sc_max;
        DQ_FIT_H: begin
          row_margin_r <= CNT_W'(m_half);
          act_h_r      <= m_act;
        end
        DQ_FIT_W: begin
          col_margin_r <= CNT_W'(m_half);
          act_w_r      <= m_act;
        end
      endcase
    end
  end

  assign empty   = (act_h_r == '0) || (act_w_r == '0);
  assign row_end = DIM_W'(row_count_r) == (act_h_r - DIM_W'(1));
  assign col_end = DIM_W'(col_count_r) == (act_w_r - DIM_W'(1));
  assign last    = row_end && col_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (cmd.derive_clr) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (cmd.out_load) begin
      if (empty || last) begin
        row_count_r <= '0;
        col_count_r <= '0;
      end else if (col_end) begin
        row_count_r <= row_count_r + CNT_W'(1);
        col_count_r <= '0;
      end else begin
        col_count_r <= col_count_r + CNT_W'(1);
      end
    end
  end

  assign sy_idx = IDX_W'(py_r >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (cmd.walk_mul) begin
      py_r    <= PY_W'(row_count_r) * PY_W'(scale_r);
      px_r    <= PY_W'(col_count_r) * PY_W'(scale_r);
      dprod_r <= (PD_W'(row_margin_r) + PD_W'(row_count_r)) * PD_W'(tw);
    end
    if (cmd.walk_add) begin
      sprod_r <= sy_idx * IDX_W'(sw);
      sx_r    <= IDX_W'(px_r >> FRAC_BITS);
      dsum_r  <= IDX_W'(dprod_r) + IDX_W'(col_margin_r) + IDX_W'(col_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (empty) begin
        out_src_r   <= '0;
        out_dst_r   <= '0;
        out_last_r  <= 1'b1;
        out_empty_r <= 1'b1;
      end else begin
        out_src_r   <= sprod_r + sx_r;
        out_dst_r   <= dsum_r;
        out_last_r  <= last;
        out_empty_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.cfg_hit   = cfg_hit;
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.empty     = empty;
    sts.slot_free = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_source_index = out_src_r;
  assign out_dest_index   = out_dst_r;
  assign out_frame_last   = out_last_r;
  assign out_empty_area   = out_empty_r;

endmodule

@@ src/ltbx_ctrl.sv @@
// ----------------------------------------------------------------------------
// ltbx_ctrl
// Controller: sequences the four divisions of the size derivation and the
// stages of one address computation, and owns the input handshake.
// ----------------------------------------------------------------------------
module ltbx_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_tick,
  input  ltbx_pkg::ltbx_sts_t  sts,
  output ltbx_pkg::ltbx_cmd_t  cmd
);

  import ltbx_pkg::*;

  typedef enum logic [8:0] {
    S_START    = 9'b000000001,
    S_DIV_SCW  = 9'b000000010,
    S_DIV_SCH  = 9'b000000100,
    S_DIV_FITH = 9'b000001000,
    S_DIV_FITW = 9'b000010000,
    S_IDLE     = 9'b000100000,
    S_MUL      = 9'b001000000,
    S_ADD      = 9'b010000000,
    S_PUT      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !sts.cfg_hit;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_START: begin
        cmd.derive_clr = 1'b1;
        state_nxt      = S_DIV_SCW;
      end
      S_DIV_SCW: begin
        cmd.div_sel = DQ_SCALE_W;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DIV_SCH;
        end else if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV_SCH: begin
        cmd.div_sel = DQ_SCALE_H;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DIV_FITH;
        end else if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV_FITH: begin
        cmd.div_sel = DQ_FIT_H;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DIV_FITW;
        end else if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV_FITW: begin
        cmd.div_sel = DQ_FIT_W;
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_IDLE;
        end else if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid && in_tick) begin
          state_nxt = sts.empty ? S_PUT : S_MUL;
        end
      end
      S_MUL: begin
        cmd.walk_mul = 1'b1;
        state_nxt    = S_ADD;
      end
      S_ADD: begin
        cmd.walk_add = 1'b1;
        state_nxt    = S_PUT;
      end
      S_PUT: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_START;
      end
    endcase
    if (sts.cfg_hit) begin
      cmd       = '0;
      state_nxt = S_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/letterbox_nearest_resize_addr_gen.sv @@
// ----------------------------------------------------------------------------
// letterbox_nearest_resize_addr_gen
// Address generator for an aspect-preserving nearest-neighbor letterbox
// resize of a one-channel frame.
// ----------------------------------------------------------------------------
// After reset and after every write to a size register the block derives the
// fixed-point scale and the centered margins with one shared bit-serial
// divider: a setup step and four divisions, during which in_ready stays low.
// A transfer with in_tick low gives no result. A transfer with in_tick high
// passes through the accept cycle, the coordinate-times-scale multiply stage,
// the source-row-times-width multiply stage and the output load, which waits
// for a free output slot. When the active area is empty the multiply stages
// are skipped and the accept leads straight to the output load. The next item
// is accepted while the loaded result still waits for out_ready.
// ----------------------------------------------------------------------------
module letterbox_nearest_resize_addr_gen #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_tick,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ltbx_pkg::IDX_W-1:0]     out_source_index,
  output logic [ltbx_pkg::IDX_W-1:0]     out_dest_index,
  output logic                           out_frame_last,
  output logic                           out_empty_area,
  input  logic                           cfg_we,
  input  logic [ltbx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ltbx_pkg::REG_W-1:0]     cfg_data
);

  import ltbx_pkg::*;

  ltbx_cmd_t cmd;
  ltbx_sts_t sts;

  ltbx_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_tick (in_tick),
    .sts     (sts),
    .cmd     (cmd)
  );

  ltbx_dp #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_source_index(out_source_index),
    .out_dest_index  (out_dest_index),
    .out_frame_last  (out_frame_last),
    .out_empty_area  (out_empty_area)
  );

endmodule
